// ===== rtl/core/cidfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Card ID frame parser package
// Shared constants and types for the card number parser with repeat
// suppression.
// ----------------------------------------------------------------------------
package cidfp_pkg;

    // Number of digits in one card number.
    localparam int ID_DIGITS = 10;
    // Width of the elapsed-tick counter.
    localparam int TICK_BITS = 16;

    // Width of the digit window (packed BCD).
    localparam int WINDOW_W  = ID_DIGITS * 4;
    // Width of an emitted card number.
    localparam int CARD_W    = 40;
    // Width of the hold-off register.
    localparam int HOLD_W    = 16;
    // Width used when comparing elapsed ticks against the hold-off value.
    localparam int CMP_W     = (TICK_BITS > HOLD_W) ? TICK_BITS : HOLD_W;
    // Width of the digit run counter, which saturates at ID_DIGITS.
    localparam int RUN_W     = $clog2(ID_DIGITS + 1);

    // Hold-off value after reset.
    localparam logic [HOLD_W-1:0] HOLD_OFF_RESET = HOLD_W'(1500);

    // Input command codes.
    typedef enum logic
    {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    // Byte codes of interest.
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_AT   = 8'h40;

    typedef logic [WINDOW_W-1:0]  window_t;
    typedef logic [CARD_W-1:0]    card_t;
    typedef logic [TICK_BITS-1:0] tick_t;
    typedef logic [RUN_W-1:0]     run_t;

endpackage

// ===== rtl/core/card_id_frame_parser_dedup.sv =====
// ----------------------------------------------------------------------------
// Card ID frame parser with repeat suppression
// Extracts ten-digit card numbers terminated by '@' from a serial byte stream
// and drops repeats of the last number seen within a hold-off window.
// ----------------------------------------------------------------------------
// Each input item is either a received serial byte or a one-millisecond tick.
// One item is accepted per cycle while in_ready is high. Its result, if any,
// is stored in the cycle after the item is accepted: in the output register
// when it is free or being emptied, and in the skid register otherwise.
// All parsing work is one short combinational step from the stored parser
// state to the next state and result, so the rate is one item per ready cycle.
// The output side has an output register backed by one skid register, so an
// item is still taken while a finished card number waits for the consumer;
// input ready drops only when both of those registers are full. Digits are
// shifted into a packed-BCD window and counted (the count saturates at the
// card length). An '@' after a full run of digits completes a card number,
// which is emitted unless it equals the last emitted number and fewer than
// hold_off_ticks ticks have passed since that emission. Any byte that is not
// a digit clears the run. The hold-off register is written through the
// configuration channel, which is always ready and must only be used while
// the block is idle.
// ----------------------------------------------------------------------------
module card_id_frame_parser_dedup
    import cidfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // Input item channel.
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [7:0]          data_byte,

    // Result channel.
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CARD_W-1:0]   card_id_bcd,

    // Configuration channel for the hold-off register.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HOLD_W-1:0]   cfg_data
);

    // Parser state.
    window_t             window_reg, window_next;
    run_t                run_reg, run_next;
    card_t               last_card_reg, last_card_next;
    logic                last_valid_reg, last_valid_next;
    tick_t               ticks_reg, ticks_next;
    logic [HOLD_W-1:0]   hold_off_reg;

    // Output register and skid register.
    logic                out_valid_reg;
    card_t               out_data_reg;
    logic                skid_valid_reg;
    card_t               skid_data_reg;

    logic                in_accept;
    logic                emit;
    card_t               card;
    logic                is_digit;
    logic                run_full;
    logic                within_hold;
    logic                pop;

    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign card_id_bcd = out_data_reg;
    assign pop         = out_valid_reg && out_ready;

    // The card number is the window, extended or cut to the output width.
    assign card     = CARD_W'(window_reg);
    assign is_digit = (data_byte >= ASCII_ZERO) && (data_byte <= ASCII_NINE);
    assign run_full = (run_reg == RUN_W'(ID_DIGITS));
    // A repeat is suppressed only while the tick count is below the hold-off.
    assign within_hold = CMP_W'(ticks_reg) < CMP_W'(hold_off_reg);

    // Next-state logic for the parser.
    always_comb
    begin
        window_next     = window_reg;
        run_next        = run_reg;
        last_card_next  = last_card_reg;
        last_valid_next = last_valid_reg;
        ticks_next      = ticks_reg;
        emit            = 1'b0;

        if (command == CMD_TICK)
        begin
            // The tick counter saturates at its maximum.
            if (ticks_reg != '1)
            begin
                ticks_next = ticks_reg + TICK_BITS'(1);
            end
        end
        else if (is_digit)
        begin
            window_next = (window_reg << 4) | WINDOW_W'(data_byte[3:0]);
            if (!run_full)
            begin
                run_next = run_reg + RUN_W'(1);
            end
        end
        else
        begin
            // Any other byte, including a complete frame, clears the run.
            window_next = '0;
            run_next    = '0;
            if ((data_byte == ASCII_AT) && run_full)
            begin
                if (!(last_valid_reg && (card == last_card_reg) && within_hold))
                begin
                    emit            = 1'b1;
                    last_card_next  = card;
                    last_valid_next = 1'b1;
                    ticks_next      = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            run_reg        <= '0;
            last_card_reg  <= '0;
            last_valid_reg <= 1'b0;
            ticks_reg      <= '0;
        end
        else if (in_accept)
        begin
            window_reg     <= window_next;
            run_reg        <= run_next;
            last_card_reg  <= last_card_next;
            last_valid_reg <= last_valid_next;
            ticks_reg      <= ticks_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off_reg <= HOLD_OFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            hold_off_reg <= cfg_data;
        end
    end

    // Output queue: a new result goes to the output register when it is free
    // or being emptied, and to the skid register otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_accept && emit;
                end
            end
            else if (!out_valid_reg)
            begin
                out_valid_reg <= in_accept && emit;
            end
            else if (in_accept && emit)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if ((pop || !out_valid_reg) && in_accept && emit)
        begin
            out_data_reg <= card;
        end

        if (out_valid_reg && !pop && in_accept && emit)
        begin
            skid_data_reg <= card;
        end
    end

`ifndef SYNTH
    // The skid register only fills behind a waiting output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    // An emitted card number restarts the elapsed-tick count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && emit) |=> (ticks_reg == '0) && last_valid_reg)
        else $error("emission did not restart the tick counter");

    // The digit run never counts beyond the card length.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= RUN_W'(ID_DIGITS))
        else $error("digit run count beyond card length");

    // Once a card has been emitted, that fact is never forgotten.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(last_valid_reg))
        else $error("last card valid flag was cleared");

    // A result produced while the skid register is empty and the output is free
    // or being emptied is stored in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && emit && !skid_valid_reg && (pop || !out_valid_reg))
        |=> out_valid_reg && (out_data_reg == $past(card)))
        else $error("emitted card number did not reach the output register");
`endif

endmodule
